[rtl/clbs_pkg.sv]
// shared types and constants for the character lcd bus sequencer
`timescale 1ns / 1ps

package clbs_pkg;

  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_INIT   = 3'd1;
  localparam logic [OP_W-1:0] OP_CMD    = 3'd2;
  localparam logic [OP_W-1:0] OP_CHAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_CURSOR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY    = 2'd2;

  localparam logic              FOUR_BIT_RESET = 1'b1;
  localparam logic [BYTE_W-1:0] DISPLAY_RESET  = 8'h0C;
  localparam logic [BYTE_W-1:0] ENTRY_RESET    = 8'h06;

  localparam logic [BYTE_W-1:0] CMD_FSET_8 = 8'h38;
  localparam logic [BYTE_W-1:0] CMD_FSET_4 = 8'h28;
  localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h01;
  localparam logic [BYTE_W-1:0] ROW0_BASE  = 8'h80;
  localparam logic [BYTE_W-1:0] ROW1_BASE  = 8'hC0;
  localparam logic [BYTE_W-1:0] HI_NIBBLE  = 8'hF0;

  typedef struct packed {
    logic              rs_pin;
    logic              en_pin;
    logic [BYTE_W-1:0] data_pins;
    logic              busy_res;
    logic              rejected;
  } result_t;

endpackage

[rtl/clbs_seq.sv]
// pin sequencer state, configuration registers and per-item result logic
`timescale 1ns / 1ps

module clbs_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [clbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clbs_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                           fire,
  input  logic [clbs_pkg::OP_W-1:0]      op,
  input  logic [clbs_pkg::BYTE_W-1:0]    value,
  input  logic                           row,
  input  logic [clbs_pkg::COL_W-1:0]     column,
  output clbs_pkg::result_t              result
);
  import clbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RS, ST_PUT_HI, ST_EN_HI, ST_EN_LO, ST_PUT_LO, ST_EN_HI2,
    ST_EN_LO2, ST_PRE_RS, ST_PRE_PUT, ST_PRE_EN_HI, ST_PRE_EN_LO, ST_GAP
  } step_t;

  logic              four_bit_mode;
  logic [BYTE_W-1:0] display_setting;
  logic [BYTE_W-1:0] entry_setting;

  step_t             seq_step, seq_step_next;
  logic [2:0]        init_stage, init_stage_next;
  logic [1:0]        wait_left, wait_left_next;
  logic [BYTE_W-1:0] held_byte, held_byte_next;
  logic              held_rs, held_rs_next;
  logic              rs, rs_next;
  logic              en, en_next;
  logic [BYTE_W-1:0] data, data_next;
  logic              rej;
  logic [BYTE_W-1:0] cursor_cmd;
  logic [BYTE_W-1:0] row_base;

  assign row_base   = row ? ROW1_BASE : ROW0_BASE;
  assign cursor_cmd = row_base + {{(BYTE_W-COL_W){1'b0}}, column} - 8'd1;

  always_comb begin
    seq_step_next   = seq_step;
    init_stage_next = init_stage;
    wait_left_next  = wait_left;
    held_byte_next  = held_byte;
    held_rs_next    = held_rs;
    rs_next         = rs;
    en_next         = en;
    data_next       = data;
    rej             = 1'b0;
    if (op == OP_TICK) begin
      if (seq_step == ST_IDLE) begin
        seq_step_next = ST_IDLE;
      end else if (wait_left != 2'd0) begin
        wait_left_next = wait_left - 2'd1;
      end else begin
        case (seq_step)
          ST_RS: begin
            rs_next       = held_rs;
            seq_step_next = ST_PUT_HI;
          end
          ST_PUT_HI: begin
            data_next     = four_bit_mode ? (held_byte & HI_NIBBLE) : held_byte;
            seq_step_next = ST_EN_HI;
          end
          ST_EN_HI: begin
            en_next       = 1'b1;
            seq_step_next = ST_EN_LO;
          end
          ST_EN_LO, ST_EN_LO2: begin
            en_next = 1'b0;
            if (four_bit_mode && seq_step == ST_EN_LO) begin
              seq_step_next = ST_PUT_LO;
            end else if (init_stage == 3'd0) begin
              seq_step_next = ST_IDLE;
            end else begin
              seq_step_next  = ST_GAP;
              wait_left_next = (init_stage == 3'd4) ? 2'd1 : 2'd0;
            end
          end
          ST_PUT_LO: begin
            data_next     = {held_byte[3:0], 4'h0};
            seq_step_next = ST_EN_HI2;
          end
          ST_EN_HI2: begin
            en_next       = 1'b1;
            seq_step_next = ST_EN_LO2;
          end
          ST_PRE_RS: begin
            rs_next       = 1'b0;
            seq_step_next = ST_PRE_PUT;
          end
          ST_PRE_PUT: begin
            data_next     = CMD_FSET_4 & HI_NIBBLE;
            seq_step_next = ST_PRE_EN_HI;
          end
          ST_PRE_EN_HI: begin
            en_next       = 1'b1;
            seq_step_next = ST_PRE_EN_LO;
          end
          ST_PRE_EN_LO: begin
            en_next       = 1'b0;
            seq_step_next = ST_RS;
          end
          ST_GAP: begin
            held_rs_next = 1'b0;
            case (init_stage)
              3'd1: begin
                init_stage_next = 3'd2;
                if (four_bit_mode) begin
                  held_byte_next = CMD_FSET_4;
                  seq_step_next  = ST_PRE_RS;
                end else begin
                  held_byte_next = CMD_FSET_8;
                  seq_step_next  = ST_RS;
                end
              end
              3'd2: begin
                init_stage_next = 3'd3;
                held_byte_next  = display_setting;
                seq_step_next   = ST_RS;
              end
              3'd3: begin
                init_stage_next = 3'd4;
                held_byte_next  = CMD_CLEAR;
                seq_step_next   = ST_RS;
              end
              3'd4: begin
                init_stage_next = 3'd5;
                held_byte_next  = entry_setting;
                seq_step_next   = ST_RS;
              end
              default: begin
                held_rs_next    = held_rs;
                init_stage_next = 3'd0;
                seq_step_next   = ST_IDLE;
              end
            endcase
          end
          default: begin
            seq_step_next   = ST_IDLE;
            init_stage_next = 3'd0;
          end
        endcase
      end
    end else if (op == OP_INIT || op == OP_CMD || op == OP_CHAR || op == OP_CURSOR) begin
      if (seq_step != ST_IDLE) begin
        rej = 1'b1;
      end else begin
        wait_left_next  = 2'd0;
        init_stage_next = 3'd0;
        seq_step_next   = ST_RS;
        case (op)
          OP_INIT: begin
            init_stage_next = 3'd1;
            seq_step_next   = ST_GAP;
            wait_left_next  = 2'd1;
          end
          OP_CMD: begin
            held_byte_next = value;
            held_rs_next   = 1'b0;
          end
          OP_CHAR: begin
            held_byte_next = value;
            held_rs_next   = 1'b1;
          end
          default: begin
            held_byte_next = cursor_cmd;
            held_rs_next   = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    result.rs_pin    = rs_next;
    result.en_pin    = en_next;
    result.data_pins = four_bit_mode ? (data_next & HI_NIBBLE) : data_next;
    result.busy_res  = (seq_step_next != ST_IDLE);
    result.rejected  = rej;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit_mode   <= FOUR_BIT_RESET;
      display_setting <= DISPLAY_RESET;
      entry_setting   <= ENTRY_RESET;
      seq_step        <= ST_IDLE;
      init_stage      <= 3'd0;
      wait_left       <= 2'd0;
      held_byte       <= '0;
      held_rs         <= 1'b0;
      rs              <= 1'b0;
      en              <= 1'b0;
      data            <= '0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          CFG_FOUR_BIT: four_bit_mode   <= cfg_data[0];
          CFG_DISPLAY:  display_setting <= cfg_data;
          CFG_ENTRY:    entry_setting   <= cfg_data;
          default:      four_bit_mode   <= four_bit_mode;
        endcase
      end
      if (fire) begin
        seq_step   <= seq_step_next;
        init_stage <= init_stage_next;
        wait_left  <= wait_left_next;
        held_byte  <= held_byte_next;
        held_rs    <= held_rs_next;
        rs         <= rs_next;
        en         <= en_next;
        data       <= data_next;
      end
    end
  end

endmodule

[rtl/clbs_out_buf.sv]
// two-entry result buffer between the sequencer and the output channel
`timescale 1ns / 1ps

module clbs_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  clbs_pkg::result_t push_data,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output clbs_pkg::result_t head,
  output logic [1:0]        fill
);
  import clbs_pkg::*;

  result_t    slot0;
  result_t    slot1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != 2'd0);
  assign has_room  = (count != 2'd2);
  assign head      = slot0;
  assign fill      = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (push && !pop) begin
            count <= 2'd2;
          end else if (!push && pop) begin
            count <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            count <= 2'd1;
          end
        end
        default: count <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: begin
        if (push) begin
          slot0 <= push_data;
        end
      end
      2'd1: begin
        if (push && pop) begin
          slot0 <= push_data;
        end else if (push) begin
          slot1 <= push_data;
        end
      end
      2'd2: begin
        if (pop) begin
          slot0 <= slot1;
        end
      end
      default: slot0 <= slot0;
    endcase
  end

endmodule

[rtl/char_lcd_bus_sequencer.sv]
// top level of the character lcd bus sequencer
// usage:
//   input channel (in_valid/in_ready) carries one item: op, value, row, column.
//   op 0 is a 1 ms tick that advances the pin sequence one step; ops 1 to 4
//   load an init, command, character or set-cursor sequence when idle and are
//   flagged rejected when a sequence is still running.
//   output channel (out_valid/out_ready) gives one item per input item: the
//   rs, en and data pin levels after that item, busy and rejected flags.
//   configuration: cfg_wen writes cfg_data into register cfg_index
//   (0 four_bit_mode, 1 display_setting, 2 entry_setting); write only while
//   idle. settings take effect at once.
//   the result is registered in the result buffer and presented once earlier
//   results are taken. throughput: one item per cycle while in_ready is high.
//   a two-entry result buffer keeps in_ready high while one result waits;
//   when the receiver stalls and both entries are full, in_ready drops.
//   reset: pin registers low, sequencer idle, registers to 4-bit mode, display
//   setting 0x0c and entry setting 0x06; the buffer empties.
`timescale 1ns / 1ps

module char_lcd_bus_sequencer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wen,
  input  logic [clbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [clbs_pkg::BYTE_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [clbs_pkg::OP_W-1:0]      op,
  input  logic [clbs_pkg::BYTE_W-1:0]    value,
  input  logic                           row,
  input  logic [clbs_pkg::COL_W-1:0]     column,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           rs_pin,
  output logic                           en_pin,
  output logic [clbs_pkg::BYTE_W-1:0]    data_pins,
  output logic                           busy_res,
  output logic                           rejected
);
  import clbs_pkg::*;

  logic       fire;
  result_t    step_res;
  result_t    head;
  logic [1:0] fill;

  assign fire = in_valid && in_ready;

  clbs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .op        (op),
    .value     (value),
    .row       (row),
    .column    (column),
    .result    (step_res)
  );

  clbs_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (step_res),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .fill      (fill)
  );

  assign rs_pin    = head.rs_pin;
  assign en_pin    = head.en_pin;
  assign data_pins = head.data_pins;
  assign busy_res  = head.busy_res;
  assign rejected  = head.rejected;

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill != 2'd3)
    else $error("result buffer fill out of range");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    (fire && step_res.rejected) |-> step_res.busy_res)
    else $error("rejected item left the sequencer idle");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && fill == 2'd2))
    else $error("input stalled without a full result buffer");

  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted item produced no result");
`endif

endmodule
